// ----- hdl/gbtd_pkg.sv -----
`timescale 1ns / 1ps

package gbtd_pkg;

    localparam int MAX_PAYLOAD = 512;
    localparam int NMEA_LINE   = 128;

    localparam int LEN_W   = 16;
    localparam int COUNT_W = $clog2(MAX_PAYLOAD + 1);
    localparam int TEXT_W  = $clog2(NMEA_LINE);

    localparam logic [7:0] SYNC_A    = 8'hB5;
    localparam logic [7:0] SYNC_B    = 8'h62;
    localparam logic [7:0] CHAR_DOLLAR = 8'h24;
    localparam logic [7:0] CHAR_CR   = 8'h0D;
    localparam logic [7:0] CHAR_LF   = 8'h0A;

    // a line store of one character is already full after the '$'
    localparam logic DOLLAR_FILLS = (NMEA_LINE - 1 <= 1);

    typedef enum logic [1:0] {
        KIND_PAYLOAD   = 2'd0,
        KIND_FRAME_END = 2'd1,
        KIND_TEXT_CHAR = 2'd2,
        KIND_LINE_END  = 2'd3
    } gbtd_kind_t;

    typedef enum logic [3:0] {
        PH_HUNT    = 4'd0,
        PH_SYNC_B  = 4'd1,
        PH_CLASS   = 4'd2,
        PH_ID      = 4'd3,
        PH_LEN_LO  = 4'd4,
        PH_LEN_HI  = 4'd5,
        PH_PAYLOAD = 4'd6,
        PH_CHECK_A = 4'd7,
        PH_CHECK_B = 4'd8
    } gbtd_phase_t;

    typedef struct packed {
        gbtd_phase_t        phase;
        logic [7:0]         held_class;
        logic [7:0]         held_id;
        logic [LEN_W-1:0]   expected_length;
        logic [COUNT_W-1:0] payload_count;
        logic [7:0]         sum_a;
        logic [7:0]         sum_b;
        logic [7:0]         first_check_byte;
        logic [TEXT_W-1:0]  text_length;
    } gbtd_state_t;

    typedef struct packed {
        gbtd_kind_t kind;
        logic [7:0] frame_class;
        logic [7:0] frame_id;
        logic [9:0] frame_length;
        logic [8:0] byte_index;
        logic [7:0] data_byte;
        logic       checksum_ok;
        logic       last;
    } gbtd_result_t;

endpackage

// ----- hdl/gbtd_step.sv -----
`timescale 1ns / 1ps

module gbtd_step (
    input  gbtd_pkg::gbtd_state_t  state,
    input  logic [7:0]             byte_in,
    output gbtd_pkg::gbtd_state_t  state_next,
    output logic                   res_valid,
    output gbtd_pkg::gbtd_result_t res
);
    import gbtd_pkg::*;

    logic [7:0]         sum_a_add;
    logic [7:0]         sum_b_add;
    logic [LEN_W-1:0]   len_full;
    logic [COUNT_W-1:0] count_inc;
    logic [TEXT_W-1:0]  text_inc;
    logic               text_path;

    assign sum_a_add = state.sum_a + byte_in;
    assign sum_b_add = state.sum_b + sum_a_add;
    assign len_full  = {byte_in, state.expected_length[7:0]};
    assign count_inc = state.payload_count + COUNT_W'(1);
    assign text_inc  = state.text_length + TEXT_W'(1);

    always_comb
    begin
        state_next = state;
        res_valid  = 1'b0;
        res        = '0;
        text_path  = 1'b0;

        unique case (state.phase)
            PH_HUNT:
            begin
                if (byte_in == SYNC_A)
                    state_next.phase = PH_SYNC_B;
                else
                    text_path = 1'b1;
            end
            PH_SYNC_B:
            begin
                if (byte_in == SYNC_B)
                    state_next.phase = PH_CLASS;
                else
                begin
                    state_next.phase = PH_HUNT;
                    text_path        = 1'b1;
                end
            end
            PH_CLASS:
            begin
                state_next.held_class = byte_in;
                state_next.sum_a      = byte_in;
                state_next.sum_b      = byte_in;
                state_next.phase      = PH_ID;
            end
            PH_ID:
            begin
                state_next.held_id = byte_in;
                state_next.sum_a   = sum_a_add;
                state_next.sum_b   = sum_b_add;
                state_next.phase   = PH_LEN_LO;
            end
            PH_LEN_LO:
            begin
                state_next.expected_length = {8'h00, byte_in};
                state_next.sum_a           = sum_a_add;
                state_next.sum_b           = sum_b_add;
                state_next.phase           = PH_LEN_HI;
            end
            PH_LEN_HI:
            begin
                state_next.expected_length = len_full;
                state_next.sum_a           = sum_a_add;
                state_next.sum_b           = sum_b_add;
                state_next.payload_count   = '0;
                if (len_full > LEN_W'(MAX_PAYLOAD))
                    state_next.phase = PH_HUNT;
                else if (len_full == '0)
                    state_next.phase = PH_CHECK_A;
                else
                    state_next.phase = PH_PAYLOAD;
            end
            PH_PAYLOAD:
            begin
                state_next.sum_a         = sum_a_add;
                state_next.sum_b         = sum_b_add;
                state_next.payload_count = count_inc;
                res_valid                = 1'b1;
                res.kind                 = KIND_PAYLOAD;
                res.frame_class          = state.held_class;
                res.frame_id             = state.held_id;
                res.frame_length         = state.expected_length[9:0];
                res.byte_index           = state.payload_count[8:0];
                res.data_byte            = byte_in;
                res.last                 = (LEN_W'(count_inc) >= state.expected_length);
                if (res.last)
                    state_next.phase = PH_CHECK_A;
            end
            PH_CHECK_A:
            begin
                state_next.first_check_byte = byte_in;
                state_next.phase            = PH_CHECK_B;
            end
            PH_CHECK_B:
            begin
                state_next.phase = PH_HUNT;
                res_valid        = 1'b1;
                res.kind         = KIND_FRAME_END;
                res.frame_class  = state.held_class;
                res.frame_id     = state.held_id;
                res.frame_length = state.expected_length[9:0];
                res.checksum_ok  = (state.first_check_byte == state.sum_a) &&
                                   (byte_in == state.sum_b);
            end
            default:
            begin
                state_next.phase = PH_HUNT;
                text_path        = 1'b1;
            end
        endcase

        if (text_path)
        begin
            if (byte_in == CHAR_DOLLAR)
            begin
                state_next.text_length = TEXT_W'(1);
                res_valid              = 1'b1;
                res.kind               = KIND_TEXT_CHAR;
                res.data_byte          = byte_in;
                res.last               = DOLLAR_FILLS;
            end
            else if (state.text_length != '0)
            begin
                if ((byte_in == CHAR_CR) || (byte_in == CHAR_LF))
                begin
                    state_next.text_length = '0;
                    res_valid              = 1'b1;
                    res.kind               = KIND_LINE_END;
                    res.frame_length       = 10'(state.text_length);
                    res.data_byte          = byte_in;
                end
                else if (state.text_length < TEXT_W'(NMEA_LINE - 1))
                begin
                    // characters past the line store are dropped silently
                    state_next.text_length = text_inc;
                    res_valid              = 1'b1;
                    res.kind               = KIND_TEXT_CHAR;
                    res.byte_index         = 9'(state.text_length);
                    res.data_byte          = byte_in;
                    res.last               = (text_inc == TEXT_W'(NMEA_LINE - 1));
                end
            end
        end
    end

endmodule

// ----- hdl/gnss_binary_and_text_deframer_core.sv -----
`timescale 1ns / 1ps

// Splits a receiver byte stream into binary frames (sync 0xB5 0x62, class, id,
// little-endian length, payload, two Fletcher-8 check bytes) and '$' text lines.
// One byte is taken per cycle while in_ready is high, and it yields at most one
// result: each payload byte, a frame end with the checksum verdict, each stored
// text character, and a line end on CR or LF. Frames declaring more than 512
// payload bytes are dropped, and line characters beyond 127 are discarded. The
// parser state updates in the accepting cycle and the result lands in an output
// register, seen in the next cycle; in_ready stays high while that register is
// empty or being drained, so the sustained rate is one byte per clock.

module gnss_binary_and_text_deframer_core (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] byte_in,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [1:0] result_kind,
    output logic [7:0] frame_class,
    output logic [7:0] frame_id,
    output logic [9:0] frame_length,
    output logic [8:0] byte_index,
    output logic [7:0] data_byte,
    output logic       checksum_ok,
    output logic       last
);
    import gbtd_pkg::*;

    gbtd_state_t  state_reg;
    gbtd_state_t  state_next;
    gbtd_result_t res_next;
    gbtd_result_t res_reg;
    logic         res_hit;
    logic         out_valid_reg;
    logic         accept;

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    gbtd_step u_step (
        .state      (state_reg),
        .byte_in    (byte_in),
        .state_next (state_next),
        .res_valid  (res_hit),
        .res        (res_next)
    );

    // all-zero state is hunting with no line open
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
                state_reg <= state_next;
            if (accept)
                out_valid_reg <= res_hit;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && res_hit)
            res_reg <= res_next;
    end

    assign out_valid    = out_valid_reg;
    assign result_kind  = res_reg.kind;
    assign frame_class  = res_reg.frame_class;
    assign frame_id     = res_reg.frame_id;
    assign frame_length = res_reg.frame_length;
    assign byte_index   = res_reg.byte_index;
    assign data_byte    = res_reg.data_byte;
    assign checksum_ok  = res_reg.checksum_ok;
    assign last         = res_reg.last;

endmodule
